/* rtl/tset_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and key helpers for the sorted event table.
package tset_pkg;

	localparam logic [1:0] CMD_INSERT       = 2'd0;
	localparam logic [1:0] CMD_REMOVE_DATE  = 2'd1;
	localparam logic [1:0] CMD_REMOVE_EXACT = 2'd2;
	localparam logic [1:0] CMD_LIST         = 2'd3;

	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_LISTED   = 2'd3;

	localparam int RESULT_LIMIT = 16;
	localparam int LIST_W       = $clog2(RESULT_LIMIT + 1);
	localparam int COUNT_W      = 7;
	localparam int DATE_W       = 23;
	localparam int KEY_W        = 34;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  start_hour;
		logic [5:0]  start_minute;
		logic [4:0]  end_hour;
		logic [5:0]  end_minute;
		logic [15:0] record_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  count;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_start_hour;
		logic [5:0]  out_start_minute;
		logic [4:0]  out_end_hour;
		logic [5:0]  out_end_minute;
		logic [15:0] out_handle;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  start_hour;
		logic [5:0]  start_minute;
		logic [4:0]  end_hour;
		logic [5:0]  end_minute;
		logic [15:0] handle;
	} entry_t;

	// shift: every cell takes its right neighbor; wr: append wdata at the first empty cell
	typedef struct packed {
		logic   shift;
		logic   wr;
		entry_t wdata;
	} chain_ctl_t;

	function automatic logic [DATE_W-1:0] date_of(entry_t e);
		return {e.year, e.month, e.day};
	endfunction

	function automatic logic [KEY_W-1:0] key_of(entry_t e);
		return {e.year, e.month, e.day, e.start_hour, e.start_minute};
	endfunction

	function automatic entry_t entry_of(req_t r);
		entry_t e;
		e.year         = r.year;
		e.month        = r.month;
		e.day          = r.day;
		e.start_hour   = r.start_hour;
		e.start_minute = r.start_minute;
		e.end_hour     = r.end_hour;
		e.end_minute   = r.end_minute;
		e.handle       = r.record_handle;
		return e;
	endfunction

	function automatic rsp_t plain_rsp(logic [1:0] status, logic [COUNT_W-1:0] count);
		rsp_t r;
		r        = '0;
		r.status = status;
		r.count  = count;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic rsp_t listed_rsp(entry_t e, logic [COUNT_W-1:0] count, logic last);
		rsp_t r;
		r.status           = STAT_LISTED;
		r.count            = count;
		r.out_year         = e.year;
		r.out_month        = e.month;
		r.out_day          = e.day;
		r.out_start_hour   = e.start_hour;
		r.out_start_minute = e.start_minute;
		r.out_end_hour     = e.end_hour;
		r.out_end_minute   = e.end_minute;
		r.out_handle       = e.handle;
		r.last             = last;
		return r;
	endfunction

endpackage

/* rtl/tset_cell.sv */
`timescale 1ns / 1ps
// One table slot: entry register and valid flag, shifting toward the head.
module tset_cell import tset_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  logic       left_valid,
	input  logic       right_valid,
	input  entry_t     right_entry,
	output logic       valid,
	output entry_t     entry
);

	logic   valid_q;
	entry_t entry_q;
	logic   cur_after;
	logic   prev_ok;
	logic   hit;

	// valid cells always form a prefix, so the first empty slot is found locally
	assign cur_after = ctl.shift ? right_valid : valid_q;
	assign prev_ok   = ctl.shift ? valid_q : left_valid;
	assign hit       = ctl.wr & ~cur_after & prev_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cur_after | hit;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			entry_q <= ctl.wdata;
		end else if (ctl.shift) begin
			entry_q <= right_entry;
		end
	end

	assign valid = valid_q;
	assign entry = entry_q;

endmodule

/* rtl/tset_ctrl.sv */
`timescale 1ns / 1ps
// Command sequencer: walks the head of the cell chain and builds results.
module tset_ctrl import tset_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  req_t          req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rsp_t          rsp,
	input  entry_t        head,
	output chain_ctl_t    ctl,
	output logic [CW-1:0] stored
);

	state_t              state_q, state_d;
	req_t                req_q;
	logic [CW-1:0]       n_q, rem_q, removed_q, n_next;
	logic [LIST_W-1:0]   k_q;
	logic                placed_q, found_q, pend_valid_q;
	entry_t              pend_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	entry_t              req_entry;
	logic                date_eq, key_eq, new_lt;
	logic                at_end, finish, list_take, need_push, out_free, go;
	logic                push;
	rsp_t                push_data, final_rsp;

	assign req_entry = entry_of(req_q);
	assign date_eq   = date_of(head) == date_of(req_entry);
	assign key_eq    = key_of(head) == key_of(req_entry);
	assign new_lt    = key_of(req_entry) < key_of(head);
	assign at_end    = rem_q == '0;
	assign finish    = at_end & (placed_q | (req_q.command != CMD_INSERT));
	assign list_take = (req_q.command == CMD_LIST) & date_eq & ~at_end
	                 & (k_q < LIST_W'(RESULT_LIMIT));
	assign need_push = finish | (list_take & pend_valid_q);
	assign out_free  = ~rsp_valid_q | rsp_ready;
	assign go        = (state_q == ST_RUN) & (~need_push | out_free);

	always_comb begin
		n_next    = n_q;
		final_rsp = plain_rsp(STAT_DONE, COUNT_W'(n_q));
		case (req_q.command)
			CMD_INSERT: begin
				if (n_q == CW'(CAPACITY)) begin
					final_rsp = plain_rsp(STAT_FULL, COUNT_W'(n_q));
				end else begin
					n_next    = n_q + CW'(1);
					final_rsp = plain_rsp(STAT_DONE, COUNT_W'(n_next));
				end
			end
			CMD_REMOVE_DATE: begin
				n_next    = n_q - removed_q;
				final_rsp = plain_rsp(STAT_DONE, COUNT_W'(removed_q));
			end
			CMD_REMOVE_EXACT: begin
				if (found_q) begin
					n_next    = n_q - CW'(1);
					final_rsp = plain_rsp(STAT_DONE, COUNT_W'(n_next));
				end else begin
					final_rsp = plain_rsp(STAT_NOTFOUND, COUNT_W'(n_q));
				end
			end
			default: begin
				if (pend_valid_q) begin
					final_rsp = listed_rsp(pend_q, COUNT_W'(n_q), 1'b1);
				end else begin
					final_rsp = plain_rsp(STAT_NOTFOUND, COUNT_W'(n_q));
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl.shift = 1'b0;
		ctl.wr    = 1'b0;
		ctl.wdata = head;
		push      = 1'b0;
		push_data = final_rsp;
		req_ready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (go && finish) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end else if (go) begin
					case (req_q.command)
						CMD_INSERT: begin
							ctl.wr = 1'b1;
							if (!placed_q && (at_end || new_lt)) begin
								ctl.wdata = req_entry;
							end else begin
								ctl.shift = 1'b1;
							end
						end
						CMD_REMOVE_DATE: begin
							ctl.shift = 1'b1;
							ctl.wr    = ~date_eq;
						end
						CMD_REMOVE_EXACT: begin
							ctl.shift = 1'b1;
							ctl.wr    = ~(key_eq & ~found_q);
						end
						default: begin
							ctl.shift = 1'b1;
							ctl.wr    = 1'b1;
							if (list_take && pend_valid_q) begin
								push      = 1'b1;
								push_data = listed_rsp(pend_q, COUNT_W'(n_q), 1'b0);
							end
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= '0;
			rem_q        <= '0;
			removed_q    <= '0;
			k_q          <= '0;
			placed_q     <= 1'b0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				rem_q        <= n_q;
				removed_q    <= '0;
				k_q          <= '0;
				placed_q     <= (req.command == CMD_INSERT) && (n_q == CW'(CAPACITY));
				found_q      <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (go && finish) begin
				n_q <= n_next;
			end else if (go) begin
				if (ctl.shift) begin
					rem_q <= rem_q - CW'(1);
				end
				if (req_q.command == CMD_INSERT && !ctl.shift) begin
					placed_q <= 1'b1;
				end
				if (req_q.command == CMD_REMOVE_DATE && date_eq) begin
					removed_q <= removed_q + CW'(1);
				end
				if (req_q.command == CMD_REMOVE_EXACT && key_eq) begin
					found_q <= 1'b1;
				end
				if (list_take) begin
					k_q          <= k_q + LIST_W'(1);
					pend_valid_q <= 1'b1;
				end
			end
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (go && !finish && list_take) begin
			pend_q <= head;
		end
		if (push) begin
			rsp_q <= push_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign stored    = n_q;

endmodule

/* rtl/timestamp_sorted_event_table.sv */
`timescale 1ns / 1ps
// Top level of the sorted event table: cell chain plus command sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_t, one command
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_t, one result, last marks the end
//
// One command at a time. With n entries stored, a command rotates the chain
// once through the head comparator and then emits its final result; an insert
// that places an entry also spends a step writing it in; one step per cycle.
// A step that emits a transaction waits while the output register holds one
// that is not taken in that cycle.
// Reset empties the table at once through the per-cell valid flags.
module timestamp_sorted_event_table import tset_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	chain_ctl_t          ctl;
	logic [CAPACITY-1:0] valid_vec;
	entry_t              entries [CAPACITY];
	logic [CW-1:0]       stored;

	tset_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.head      (entries[0]),
		.ctl       (ctl),
		.stored    (stored)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_v;
		logic   right_v;
		entry_t right_e;
		if (i == 0) begin : g_first
			assign left_v = 1'b1;
		end else begin : g_mid
			assign left_v = valid_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_v = 1'b0;
			assign right_e = '0;
		end else begin : g_body
			assign right_v = valid_vec[i+1];
			assign right_e = entries[i+1];
		end
		tset_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_valid  (left_v),
			.right_valid (right_v),
			.right_entry (right_e),
			.valid       (valid_vec[i]),
			.entry       (entries[i])
		);
	end

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + CAPACITY'(1))) == '0)
		else $error("occupied cells are not contiguous from the head");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> ($countones(valid_vec) == int'(stored)))
		else $error("stored count disagrees with occupied cells");

	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_LISTED) |-> rsp.last)
		else $error("non-listed transaction without last");

endmodule
